// ===== rtl/ngsv_pkg.sv =====
// Shared types and character constants for the GSV satellite counter.
package ngsv_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_V      = 8'h56;

  // Header positions; the position counter stops at HDR_LEN.
  localparam logic [2:0] POS_DOLLAR = 3'd0;
  localparam logic [2:0] POS_TALK0  = 3'd1;
  localparam logic [2:0] POS_TALK1  = 3'd2;
  localparam logic [2:0] POS_TYPE0  = 3'd3;
  localparam logic [2:0] POS_TYPE1  = 3'd4;
  localparam logic [2:0] POS_TYPE2  = 3'd5;
  localparam logic [2:0] HDR_LEN    = 3'd7;

  // Talker code: bit 2 = known talker, bits 1..0 = constellation.
  localparam logic [2:0] TALK_NONE = 3'd0;
  localparam logic [2:0] TALK_G    = 3'd1;
  localparam logic [2:0] TALK_B    = 3'd2;
  localparam logic [2:0] TALK_GPS  = 3'd4;
  localparam logic [2:0] TALK_GLO  = 3'd5;
  localparam logic [2:0] TALK_BDS  = 3'd6;
  localparam logic [2:0] TALK_GAL  = 3'd7;

  // Field counter codes.
  localparam logic [1:0] FLD_HEAD  = 2'd0;
  localparam logic [1:0] FLD_MSG   = 2'd1;
  localparam logic [1:0] FLD_SATS  = 2'd2;
  localparam logic [1:0] FLD_SAT   = 2'd3;
  localparam logic [1:0] PHASE_SNR = 2'd0;

  typedef struct packed {
    logic       ok;
    logic [1:0] constellation;
    logic       first;
    logic [7:0] tracked;
    logic [7:0] sats;
    logic [7:0] best_snr;
  } line_sum_t;

  typedef struct packed {
    logic       any_valid;
    logic [7:0] max_snr;
    logic [7:0] tracked;
    logic [7:0] in_view;
    logic [1:0] constellation;
    logic       accepted;
  } result_t;

endpackage

// ===== rtl/nmea_gsv_satellite_counter.sv =====
// Top level of the NMEA GSV satellite counter.
// Takes one character word per cycle, back to back, whenever the line queue has room.
// A result word follows each end-of-line word once it is accepted, passing through the
// two-entry line queue and then the output register, which can stall on the result side.
// One word per cycle; table update retires one line per cycle unless output stalls.
// Synchronous active-high reset clears all counts, tables, the queue and the output valid.
module nmea_gsv_satellite_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] ch
  input  logic        s_axis_tlast,  // end_of_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [2:1] constellation, [10:3] in_view, [18:11] tracked,
  // [26:19] max_snr, [27] any_valid, [31:28] zero
  output logic [31:0] m_axis_tdata
);

  logic                push;
  logic                q_full;
  logic                q_valid;
  logic                pop;
  ngsv_pkg::line_sum_t push_data;
  ngsv_pkg::line_sum_t head;
  ngsv_pkg::result_t   out_data;

  ngsv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .ch          (s_axis_tdata),
    .end_of_line (s_axis_tlast),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  ngsv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (head)
  );

  ngsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {4'b0000, out_data};

endmodule

// ===== rtl/ngsv_front.sv =====
// Character parser: header check, field scan, per-line summary on end of line.
module ngsv_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           ch,
  input  logic                 end_of_line,
  output logic                 push,
  output ngsv_pkg::line_sum_t  push_data,
  input  logic                 q_full
);

  typedef enum logic [2:0] {
    SCAN_LEAD   = 3'b001,
    SCAN_DIGITS = 3'b010,
    SCAN_STOP   = 3'b100
  } scan_t;

  logic [2:0] pos, pos_next;
  logic       header_ok, hdr_next;
  logic [2:0] talker, talk_next;
  logic [1:0] fld, fld_next;
  logic [1:0] phase, phase_next;
  logic [7:0] mag, mag_next;
  logic       neg, neg_next;
  scan_t      scan, scan_next;
  logic       first, first_c;
  logic [7:0] sats, sats_c;
  logic [7:0] trk, trk_c;
  logic [7:0] best, best_c;
  logic       line_cut;

  logic       accept;
  logic       c_hdr;
  logic [2:0] c_talk;
  logic       snr_hit;
  logic       digit, space;
  logic [11:0] acc;
  logic [7:0]  acc_sat;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign digit = (ch >= ngsv_pkg::CH_ZERO) && (ch <= ngsv_pkg::CH_NINE);
  assign space = (ch == ngsv_pkg::CH_SPACE) ||
                 ((ch >= ngsv_pkg::CH_TAB) && (ch <= ngsv_pkg::CH_CR));
  assign acc     = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {8'd0, ch[3:0]};
  assign acc_sat = (acc > 12'd255) ? 8'hFF : acc[7:0];

  // Header tracking for the current character.
  always_comb begin
    hdr_next  = header_ok;
    talk_next = talker;
    unique case (pos)
      ngsv_pkg::POS_DOLLAR: begin
        if (ch != ngsv_pkg::CH_DOLLAR) hdr_next = 1'b0;
      end
      ngsv_pkg::POS_TALK0: begin
        priority if (ch == ngsv_pkg::CH_G) talk_next = ngsv_pkg::TALK_G;
        else if (ch == ngsv_pkg::CH_B)     talk_next = ngsv_pkg::TALK_B;
        else                               talk_next = ngsv_pkg::TALK_NONE;
      end
      ngsv_pkg::POS_TALK1: begin
        priority if (talker == ngsv_pkg::TALK_G) begin
          priority if (ch == ngsv_pkg::CH_P) talk_next = ngsv_pkg::TALK_GPS;
          else if (ch == ngsv_pkg::CH_L)     talk_next = ngsv_pkg::TALK_GLO;
          else if (ch == ngsv_pkg::CH_B)     talk_next = ngsv_pkg::TALK_BDS;
          else if (ch == ngsv_pkg::CH_A)     talk_next = ngsv_pkg::TALK_GAL;
          else                               talk_next = ngsv_pkg::TALK_NONE;
        end else if (talker == ngsv_pkg::TALK_B && ch == ngsv_pkg::CH_D) begin
          talk_next = ngsv_pkg::TALK_BDS;
        end else begin
          talk_next = ngsv_pkg::TALK_NONE;
        end
      end
      ngsv_pkg::POS_TYPE0: begin
        if (ch != ngsv_pkg::CH_G) hdr_next = 1'b0;
      end
      ngsv_pkg::POS_TYPE1: begin
        if (ch != ngsv_pkg::CH_S) hdr_next = 1'b0;
      end
      ngsv_pkg::POS_TYPE2: begin
        if (ch != ngsv_pkg::CH_V) hdr_next = 1'b0;
      end
      default: ;
    endcase
    pos_next = (pos < ngsv_pkg::HDR_LEN) ? pos + 3'd1 : pos;
  end

  // Field commit: on a comma the header seen includes the comma itself.
  always_comb begin
    c_hdr   = end_of_line ? header_ok : hdr_next;
    c_talk  = end_of_line ? talker : talk_next;
    first_c = first;
    sats_c  = sats;
    trk_c   = trk;
    best_c  = best;
    snr_hit = (fld == ngsv_pkg::FLD_SAT) && (phase == ngsv_pkg::PHASE_SNR) &&
              !neg && (mag != 8'd0) && c_hdr && c_talk[2];
    unique case (fld)
      ngsv_pkg::FLD_MSG:  first_c = neg || (mag <= 8'd1);
      ngsv_pkg::FLD_SATS: sats_c  = neg ? (8'd0 - mag) : mag;
      ngsv_pkg::FLD_SAT: begin
        if (snr_hit) begin
          trk_c = trk + 8'd1;
          if (mag > best) best_c = mag;
        end
      end
      default: ;
    endcase
  end

  // Field advance and numeric scan.
  always_comb begin
    fld_next   = fld;
    phase_next = phase;
    unique case (fld)
      ngsv_pkg::FLD_HEAD: begin
        if (phase == 2'd0) begin
          phase_next = 2'd1;
        end else begin
          fld_next   = ngsv_pkg::FLD_MSG;
          phase_next = 2'd0;
        end
      end
      ngsv_pkg::FLD_MSG:  fld_next = ngsv_pkg::FLD_SATS;
      ngsv_pkg::FLD_SATS: begin
        fld_next   = ngsv_pkg::FLD_SAT;
        phase_next = 2'd1;
      end
      default: phase_next = phase + 2'd1;
    endcase

    mag_next  = mag;
    neg_next  = neg;
    scan_next = scan;
    unique case (scan)
      SCAN_LEAD: begin
        priority if (space) begin
          scan_next = SCAN_LEAD;
        end else if (ch == ngsv_pkg::CH_PLUS || ch == ngsv_pkg::CH_MINUS) begin
          neg_next  = (ch == ngsv_pkg::CH_MINUS);
          scan_next = SCAN_DIGITS;
        end else if (!digit) begin
          scan_next = SCAN_STOP;
        end else begin
          scan_next = SCAN_DIGITS;
          mag_next  = acc_sat;
        end
      end
      SCAN_DIGITS: begin
        if (!digit) scan_next = SCAN_STOP;
        else        mag_next  = acc_sat;
      end
      default: ;
    endcase
  end

  assign push = accept && end_of_line;
  always_comb begin
    push_data.ok            = header_ok && (pos == ngsv_pkg::HDR_LEN) && talker[2] &&
                              (fld >= ngsv_pkg::FLD_SATS);
    push_data.constellation = talker[1:0];
    push_data.first         = first_c;
    push_data.tracked       = trk_c;
    push_data.sats          = sats_c;
    push_data.best_snr      = best_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 3'd0;
      header_ok <= 1'b1;
      talker    <= ngsv_pkg::TALK_NONE;
      fld       <= ngsv_pkg::FLD_HEAD;
      phase     <= 2'd0;
      mag       <= 8'd0;
      neg       <= 1'b0;
      scan      <= SCAN_LEAD;
      first     <= 1'b0;
      sats      <= 8'd0;
      trk       <= 8'd0;
      best      <= 8'd0;
      line_cut  <= 1'b0;
    end else if (accept) begin
      if (end_of_line) begin
        // Close the line and start the next one clean; the best SNR carries over.
        pos       <= 3'd0;
        header_ok <= 1'b1;
        talker    <= ngsv_pkg::TALK_NONE;
        fld       <= ngsv_pkg::FLD_HEAD;
        phase     <= 2'd0;
        mag       <= 8'd0;
        neg       <= 1'b0;
        scan      <= SCAN_LEAD;
        first     <= 1'b0;
        sats      <= 8'd0;
        trk       <= 8'd0;
        best      <= best_c;
        line_cut  <= 1'b0;
      end else if (!line_cut) begin
        if (ch == ngsv_pkg::CH_NUL) begin
          // Drop the rest of the line text.
          line_cut <= 1'b1;
        end else begin
          pos       <= pos_next;
          header_ok <= hdr_next;
          talker    <= talk_next;
          if (ch == ngsv_pkg::CH_COMMA) begin
            first <= first_c;
            sats  <= sats_c;
            trk   <= trk_c;
            best  <= best_c;
            fld   <= fld_next;
            phase <= phase_next;
            mag   <= 8'd0;
            neg   <= 1'b0;
            scan  <= SCAN_LEAD;
          end else begin
            mag  <= mag_next;
            neg  <= neg_next;
            scan <= scan_next;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/ngsv_queue.sv =====
// Two-entry queue of line summaries between parser and table update.
module ngsv_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ngsv_pkg::line_sum_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output ngsv_pkg::line_sum_t  head
);

  ngsv_pkg::line_sum_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !valid))
    else $error("pop from empty queue");

endmodule

// ===== rtl/ngsv_back.sv =====
// Table update: burst totals, in-view values and the registered result word.
module ngsv_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  ngsv_pkg::line_sum_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ngsv_pkg::result_t    out_data
);

  logic [7:0] burst [4];
  logic [7:0] view  [4];
  logic       seen_valid;
  logic [1:0] k;
  logic [7:0] burst_new;
  ngsv_pkg::result_t res;

  assign k         = head.constellation;
  assign burst_new = (head.first ? 8'd0 : burst[k]) + head.tracked;
  assign pop       = q_valid && (!out_valid || out_ready);

  always_comb begin
    res.accepted      = head.ok;
    res.constellation = head.ok ? k : 2'd0;
    res.in_view       = head.ok ? head.sats : 8'd0;
    res.tracked       = head.ok ? burst_new : 8'd0;
    res.max_snr       = head.best_snr;
    res.any_valid     = head.ok || seen_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        burst[i] <= 8'd0;
        view[i]  <= 8'd0;
      end
      seen_valid <= 1'b0;
    end else if (pop && head.ok) begin
      burst[k]   <= burst_new;
      view[k]    <= head.sats;
      seen_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= res;
  end

  a_seen_sticky: assert property (@(posedge clk) disable iff (rst)
    seen_valid |=> seen_valid)
    else $error("seen flag dropped");
  a_accept_sets_any: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |-> out_data.any_valid && seen_valid)
    else $error("accepted word without any_valid");
  a_view_written: assert property (@(posedge clk) disable iff (rst)
    pop && head.ok |=> view[$past(k)] == $past(head.sats))
    else $error("in-view table not updated");

endmodule

// ===== verif/gsv_checker.sv =====
`timescale 1ns / 100ps
// Stream monitor for the GSV satellite counter: predicts each line result and compares it.
module gsv_checker
  import ngsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          errors,
  output int          pending
);

  typedef enum logic [1:0] {SCAN_LEAD, SCAN_DIGITS, SCAN_STOP} scan_t;

  // Per-line parse state
  logic [2:0] pos;
  logic       hdr_ok;
  logic [2:0] talker;
  logic [1:0] fld;
  logic [1:0] phase;
  logic [7:0] mag;
  logic       neg;
  scan_t      scan;
  logic       msg_first;
  logic [7:0] sats;
  logic [7:0] trk_line;
  logic       line_cut;

  // Persistent counts
  logic [7:0] peak_snr;
  logic [7:0] burst_sum [4];
  logic [7:0] view_tab  [4];
  logic       seen_any;

  result_t expected_lines [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function void clear_value();
    mag  = '0;
    neg  = 1'b0;
    scan = SCAN_LEAD;
  endfunction

  function void clear_line();
    pos       = '0;
    hdr_ok    = 1'b1;
    talker    = TALK_NONE;
    fld       = FLD_HEAD;
    phase     = PHASE_SNR;
    clear_value();
    msg_first = 1'b0;
    sats      = '0;
    trk_line  = '0;
    line_cut  = 1'b0;
  endfunction

  function void reset_model();
    clear_line();
    peak_snr = '0;
    seen_any = 1'b0;
    for (int i = 0; i < 4; i++) begin
      burst_sum[i] = '0;
      view_tab[i]  = '0;
    end
  endfunction

  function logic is_ws(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function void commit_field();
    case (fld)
      FLD_MSG:  msg_first = neg || mag <= 8'd1;
      FLD_SATS: sats = neg ? (8'd0 - mag) : mag;
      FLD_SAT: begin
        // SNR only counts once header and talker are both good
        if (phase == PHASE_SNR && !neg && mag != 8'd0 && hdr_ok && talker[2]) begin
          trk_line = trk_line + 8'd1;
          if (mag > peak_snr) peak_snr = mag;
        end
      end
      default: ;
    endcase
  endfunction

  function void next_field();
    case (fld)
      FLD_HEAD: begin
        if (phase == PHASE_SNR) begin
          phase = phase + 2'd1;
        end else begin
          fld   = FLD_MSG;
          phase = PHASE_SNR;
        end
      end
      FLD_MSG:  fld = FLD_SATS;
      FLD_SATS: begin
        // field 4 sits one step past the SNR slot of its block
        fld   = FLD_SAT;
        phase = PHASE_SNR + 2'd1;
      end
      default:  phase = phase + 2'd1;
    endcase
  endfunction

  function void check_header(logic [7:0] c);
    case (pos)
      POS_DOLLAR: if (c != CH_DOLLAR) hdr_ok = 1'b0;
      POS_TALK0:  talker = (c == CH_G) ? TALK_G : ((c == CH_B) ? TALK_B : TALK_NONE);
      POS_TALK1: begin
        if (talker == TALK_G) begin
          case (c)
            CH_P:    talker = TALK_GPS;
            CH_L:    talker = TALK_GLO;
            CH_B:    talker = TALK_BDS;
            CH_A:    talker = TALK_GAL;
            default: talker = TALK_NONE;
          endcase
        end else if (talker == TALK_B && c == CH_D) begin
          talker = TALK_BDS;
        end else begin
          talker = TALK_NONE;
        end
      end
      POS_TYPE0: if (c != CH_G) hdr_ok = 1'b0;
      POS_TYPE1: if (c != CH_S) hdr_ok = 1'b0;
      POS_TYPE2: if (c != CH_V) hdr_ok = 1'b0;
      default: ;
    endcase
    if (pos < HDR_LEN) pos = pos + 3'd1;
  endfunction

  function void scan_value(logic [7:0] c);
    logic is_dig;
    logic take;
    int   acc;
    is_dig = c >= CH_ZERO && c <= CH_NINE;
    take   = 1'b0;
    case (scan)
      SCAN_LEAD: begin
        if (is_ws(c)) begin
          take = 1'b0;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg  = (c == CH_MINUS);
          scan = SCAN_DIGITS;
        end else if (!is_dig) begin
          scan = SCAN_STOP;
        end else begin
          scan = SCAN_DIGITS;
          take = 1'b1;
        end
      end
      SCAN_DIGITS: begin
        if (is_dig) take = 1'b1;
        else scan = SCAN_STOP;
      end
      default: ;
    endcase
    if (take) begin
      acc = int'(mag) * 10 + int'(c) - int'(CH_ZERO);
      mag = (acc > 255) ? 8'd255 : acc[7:0];
    end
  endfunction

  function void parse_char(logic [7:0] c);
    if (line_cut) begin
      line_cut = 1'b1;
    end else if (c == CH_NUL) begin
      // drop the rest of the line text
      line_cut = 1'b1;
    end else begin
      check_header(c);
      if (c == CH_COMMA) begin
        commit_field();
        next_field();
        clear_value();
      end else begin
        scan_value(c);
      end
    end
  endfunction

  function result_t close_line();
    result_t    r;
    logic       ok;
    logic [1:0] k;
    commit_field();
    r  = '0;
    ok = hdr_ok && pos >= HDR_LEN && talker[2] && fld >= FLD_SATS;
    if (ok) begin
      k = talker[1:0];
      if (msg_first) burst_sum[k] = '0;
      burst_sum[k]    = burst_sum[k] + trk_line;
      view_tab[k]     = sats;
      seen_any        = 1'b1;
      r.accepted      = 1'b1;
      r.constellation = k;
      r.in_view       = view_tab[k];
      r.tracked       = burst_sum[k];
    end
    r.max_snr   = peak_snr;
    r.any_valid = seen_any;
    clear_line();
    return r;
  endfunction

  task automatic flag_error(input string what, input int want, input int got);
    errors++;
    if (errors <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      reset_model();
      expected_lines.delete();
    end else begin
      // retire the output word before taking a new input word
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[27:0];
        if (expected_lines.size() == 0) begin
          flag_error("result word with no line pending", 0, int'(m_axis_tdata));
        end else begin
          want = expected_lines.pop_front();
          if (want.accepted != got.accepted)
            flag_error("accepted", want.accepted, got.accepted);
          if (want.constellation != got.constellation)
            flag_error("constellation", want.constellation, got.constellation);
          if (want.in_view != got.in_view)
            flag_error("in_view", want.in_view, got.in_view);
          if (want.tracked != got.tracked)
            flag_error("tracked", want.tracked, got.tracked);
          if (want.max_snr != got.max_snr)
            flag_error("max_snr", want.max_snr, got.max_snr);
          if (want.any_valid != got.any_valid)
            flag_error("any_valid", want.any_valid, got.any_valid);
          if (m_axis_tdata[31:28] != 4'd0)
            flag_error("pad bits", 0, m_axis_tdata[31:28]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tlast) expected_lines.push_back(close_line());
        else parse_char(s_axis_tdata);
      end
    end
    pending = expected_lines.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for the GSV satellite counter: clock, reset, sentence stimulus and verdict.
module testbench;
  import ngsv_pkg::*;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         RANDOM_WORDS = 1480;
  localparam logic [7:0] CH_STAR      = 8'h2A;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  int errors;
  int pending;
  int cycles = 0;
  int words_sent = 0;
  bit idling = 1'b0;
  bit hold_req = 1'b0;

  logic [7:0] line_buf [$];

  nmea_gsv_satellite_counter u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gsv_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one word and hold it until it is taken; returns at the next falling edge.
  task automatic send_word(input logic [7:0] ch, input logic eol);
    if (idling && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eol;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic put_ch(input logic [7:0] c);
    line_buf.push_back(c);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic send_line();
    while (line_buf.size() != 0) send_word(line_buf.pop_front(), 1'b0);
    // character on the end-of-line word is don't-care
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    put_str(s);
    send_line();
  endtask

  // Decimal field with optional white space, sign, overlong digits and trailing junk.
  task automatic put_num(input int max_digits, input bit allow_big);
    int n;
    logic [7:0] ws;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        ws = 8'($urandom_range(9, 14));
        put_ch(ws == 8'd14 ? CH_SPACE : ws);
      end
    end
    case ($urandom_range(0, 7))
      0:       put_ch(CH_MINUS);
      1:       put_ch(CH_PLUS);
      default: ;
    endcase
    n = $urandom_range(0, max_digits);
    if (allow_big && $urandom_range(0, 5) == 0) n = $urandom_range(3, 6);
    repeat (n) put_ch(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 11) == 0) put_ch(8'(CH_A + $urandom_range(0, 25)));
  endtask

  task automatic build_sentence(input bit allow_big);
    put_ch(CH_DOLLAR);
    case ($urandom_range(0, 5))
      0: put_str("GP");
      1: put_str("GL");
      2: put_str("GB");
      3: put_str("BD");
      4: put_str("GA");
      default: begin
        put_ch($urandom_range(0, 1) ? CH_G : CH_B);
        put_ch(8'(CH_A + $urandom_range(0, 25)));
      end
    endcase
    put_str("GSV");
    put_ch(CH_COMMA); put_num(1, 1'b1);
    put_ch(CH_COMMA); put_num(1, 1'b1);
    put_ch(CH_COMMA); put_num(2, 1'b1);
    repeat ($urandom_range(0, 4)) begin
      for (int f = 0; f < 4; f++) begin
        put_ch(CH_COMMA);
        // keep SNR short until late so the peak does not pin at 255 early
        put_num(2, f != 3 || allow_big);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      put_ch(CH_STAR);
      put_ch(8'(CH_ZERO + $urandom_range(0, 9)));
      put_ch(8'(CH_A + $urandom_range(0, 5)));
    end
    if ($urandom_range(0, 9) == 0)
      line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 15) == 0)
      line_buf[$urandom_range(0, line_buf.size() - 1)] = CH_NUL;
    if ($urandom_range(0, 15) == 0)
      repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
  endtask

  task automatic build_noise();
    case ($urandom_range(0, 3))
      0: ;
      1: repeat ($urandom_range(1, 12)) put_ch(8'($urandom_range(0, 255)));
      2: begin
        put_str("$GPGSV,1,1");
        repeat ($urandom_range(1, 10)) void'(line_buf.pop_back());
      end
      default: begin
        put_ch(CH_DOLLAR);
        repeat ($urandom_range(2, 14)) put_ch(8'($urandom_range(8'h20, 8'h7E)));
      end
    endcase
  endtask

  initial begin
    int start;
    int rel;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed lines: each talker, signs, white space, saturation, rejects, cut line
    idling = 1'b1;
    send_text("$GPGSV,1,1,05,01,40,083,46");
    send_text("$GLGSV,2,2,-300,1,2,3,12");
    send_text("$BDGSV,1,0, 12,x,x,x,+30*5A");
    send_text("$GBGSV,1,-3,7,,,,-20,,,,40");
    send_text("$GAGSV,1,1,999");
    send_text("$GPGSV,2,2,3,,,,7");
    send_text("$GNGSV,1,1,04,,,,50");
    send_text("#GPGSV,1,1,04,,,,50");
    send_text("$GPGSA,1,1,04");
    send_text("$BLGSV,1,1,04");
    send_text("$GPGSV,1");
    send_text("$GPGS");
    send_text("");
    put_str("$GPGSV,1,1,09,,,,33");
    put_ch(CH_NUL);
    put_str(",,,,99");
    send_line();
    put_str("$GAGSV,1,1,");
    put_ch(CH_TAB);
    put_ch(CH_CR);
    put_str("+0007,,,,  -0,,,,8");
    send_line();

    // Hold the result side off while lines keep coming so the input backs up
    hold_req = 1'b1;
    repeat (6) send_text("");
    repeat (4) begin
      build_sentence(1'b0);
      send_line();
    end

    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      rel    = words_sent - start;
      idling = (rel < 780) || (rel >= 980 && rel < 1180);
      if ($urandom_range(0, 9) < 8) build_sentence(rel > 1020);
      else build_noise();
      send_line();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
